// ----- design/mi3_pkg.sv -----
// Package with shared constants, types and address tables for the 3x3 matrix inverse.
`default_nettype none
package mi3_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_IN_WIDTH  = 24;
    localparam int OUT_WIDTH     = 32;
    localparam int N_ELEM        = 9;
    localparam int N_COF_STEPS   = 36;

    // Element addresses for the two products of each cofactor, four per cofactor, in order.
    localparam logic [3:0] COF_ADDR [N_COF_STEPS] = '{
        4'd4, 4'd8, 4'd5, 4'd7,
        4'd5, 4'd6, 4'd3, 4'd8,
        4'd3, 4'd7, 4'd4, 4'd6,
        4'd7, 4'd2, 4'd8, 4'd1,
        4'd8, 4'd0, 4'd6, 4'd2,
        4'd6, 4'd1, 4'd7, 4'd0,
        4'd1, 4'd5, 4'd2, 4'd4,
        4'd2, 4'd3, 4'd0, 4'd5,
        4'd0, 4'd4, 4'd1, 4'd3
    };

    // Cofactor address of each output, which transposes the cofactor matrix.
    localparam logic [3:0] TRANS_ADDR [N_ELEM] = '{
        4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8
    };

    typedef enum logic [2:0] {
        S_LOAD,
        S_COF,
        S_DET,
        S_DREAD,
        S_DSTART,
        S_DWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] value;
        logic                 sat;
    } t_div_res;

endpackage
`default_nettype wire

// ----- design/mi3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mi3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 9
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- design/mi3_div.sv -----
// Restoring divider, one quotient bit per cycle, with saturation to a signed 32-bit result.
`default_nettype none
module mi3_div
    import mi3_pkg::*;
#(
    parameter int NUM_W = 81,
    parameter int DEN_W = 74
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic             i_neg,
    output logic                  o_done,
    output t_div_res              o_res
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [OUT_WIDTH:0]   r_q;
    logic                 r_ovf;
    logic                 r_neg;
    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DEN_W:0]       shifted;
    logic [DEN_W:0]       diff;
    logic                 ge;
    logic                 sat_pos;
    logic                 sat_neg;

    assign shifted = {r_rem, r_num[NUM_W-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_neg <= i_neg;
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_q   <= {r_q[OUT_WIDTH-1:0], ge};
            r_ovf <= r_ovf | r_q[OUT_WIDTH];
        end
    end

    assign sat_pos = r_ovf | r_q[OUT_WIDTH] | r_q[OUT_WIDTH-1];
    assign sat_neg = r_ovf | r_q[OUT_WIDTH] | (r_q[OUT_WIDTH-1] & (|r_q[OUT_WIDTH-2:0]));

    always_comb begin
        if (r_neg) begin
            o_res.sat   = sat_neg;
            o_res.value = sat_neg ? {1'b1, {(OUT_WIDTH-1){1'b0}}}
                                  : (~r_q[OUT_WIDTH-1:0] + 1'b1);
        end else begin
            o_res.sat   = sat_pos;
            o_res.value = sat_pos ? {1'b0, {(OUT_WIDTH-1){1'b1}}} : r_q[OUT_WIDTH-1:0];
        end
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

// ----- design/matrix_inverse_3x3.sv -----
// Sequence: nine input beats, then the cofactors and then the determinant are formed.
// Each of the nine results then reads its cofactor and, unless the determinant is zero,
// waits on the bit-serial divider; output stalls hold the result beat.
// No input is taken between the ninth element and the last result beat.
// Reset: synchronous, active low; clears the element count and the sequencer.
`default_nettype none
module matrix_inverse_3x3
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int IN_WIDTH  = DEF_IN_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [IN_WIDTH-1:0]  i_element,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [OUT_WIDTH-1:0]      o_value,
    output logic                      o_singular,
    output logic                      o_saturated,
    output logic                      o_last
);

    localparam int W  = IN_WIDTH;
    localparam int PW = 2 * W + 1;
    localparam int DW = 3 * W + 2;
    localparam int NW = PW + 2 * FRAC_BITS;

    t_state               r_state, n_state;
    logic [3:0]           r_cnt, n_cnt;
    logic [5:0]           r_step, n_step;
    logic [1:0]           r_j, n_j;
    logic [1:0]           r_dph, n_dph;
    logic [3:0]           r_o, n_o;
    logic signed [W-1:0]  r_a, n_a;
    logic [PW-1:0]        r_c, n_c;
    logic signed [PW-1:0] r_acc, n_acc;
    logic signed [DW-1:0] r_det, n_det;
    logic [OUT_WIDTH-1:0] r_value, n_value;
    logic                 r_sing, n_sing;
    logic                 r_sat, n_sat;

    logic                 e_we;
    logic [3:0]           e_raddr;
    logic [W-1:0]         rd_e;
    logic                 c_we;
    logic [3:0]           c_waddr;
    logic [3:0]           c_raddr;
    logic [PW-1:0]        c_wdata;
    logic [PW-1:0]        rd_c;
    logic [5:0]           sm1;
    logic signed [W:0]    m_y;
    logic signed [PW-1:0] prod;
    logic [PW-1:0]        c_mag;
    logic [DW-1:0]        det_mag;
    logic                 div_start;
    logic                 div_done;
    t_div_res             div_res;

    assign e_we = (r_state == S_LOAD) && i_valid;

    mi3_ram #(.WIDTH(W), .DEPTH(N_ELEM)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (r_cnt),
        .i_wdata (i_element),
        .i_raddr (e_raddr),
        .o_rdata (rd_e)
    );

    mi3_ram #(.WIDTH(PW), .DEPTH(N_ELEM)) u_cof_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (rd_c)
    );

    assign prod    = r_a * m_y;
    assign sm1     = r_step - 1'b1;
    assign c_waddr = sm1[5:2];
    assign c_wdata = r_acc - prod;
    assign c_mag   = rd_c[PW-1] ? (~rd_c + 1'b1) : rd_c;
    assign det_mag = r_det[DW-1] ? DW'(-r_det) : DW'(r_det);

    mi3_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({c_mag, {(2 * FRAC_BITS){1'b0}}}),
        .i_den   (det_mag),
        .i_neg   (rd_c[PW-1] ^ r_det[DW-1]),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_step  <= '0;
            r_j     <= '0;
            r_dph   <= '0;
            r_o     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_j     <= n_j;
            r_dph   <= n_dph;
            r_o     <= n_o;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_c     <= n_c;
        r_acc   <= n_acc;
        r_det   <= n_det;
        r_value <= n_value;
        r_sing  <= n_sing;
        r_sat   <= n_sat;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_step    = r_step;
        n_j       = r_j;
        n_dph     = r_dph;
        n_o       = r_o;
        n_a       = r_a;
        n_c       = r_c;
        n_acc     = r_acc;
        n_det     = r_det;
        n_value   = r_value;
        n_sing    = r_sing;
        n_sat     = r_sat;
        e_raddr   = '0;
        c_raddr   = '0;
        c_we      = 1'b0;
        div_start = 1'b0;
        m_y       = (W+1)'(signed'(rd_e));
        case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (r_cnt == 4'(N_ELEM - 1)) begin
                        n_cnt   = '0;
                        n_step  = '0;
                        n_state = S_COF;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_COF: begin
                if (r_step < 6'(N_COF_STEPS)) begin
                    e_raddr = COF_ADDR[r_step];
                end
                if (r_step != '0) begin
                    case (sm1[1:0])
                        2'd0: n_a = signed'(rd_e);
                        2'd1: n_acc = prod;
                        2'd2: n_a = signed'(rd_e);
                        default: c_we = 1'b1;
                    endcase
                end
                n_step = r_step + 1'b1;
                if (r_step == 6'(N_COF_STEPS)) begin
                    n_det   = '0;
                    n_j     = '0;
                    n_dph   = '0;
                    n_state = S_DET;
                end
            end
            S_DET: begin
                n_dph = r_dph + 1'b1;
                case (r_dph)
                    2'd0: begin
                        e_raddr = {2'b00, r_j};
                        c_raddr = {2'b00, r_j};
                    end
                    2'd1: begin
                        n_a = signed'(rd_e);
                        n_c = rd_c;
                    end
                    2'd2: begin
                        m_y   = signed'({1'b0, r_c[W-1:0]});
                        n_det = r_det + DW'(prod);
                    end
                    default: begin
                        m_y   = signed'(r_c[PW-1:W]);
                        n_det = r_det + (DW'(prod) <<< W);
                        n_j   = r_j + 1'b1;
                        if (r_j == 2'd2) begin
                            n_o     = '0;
                            n_state = S_DREAD;
                        end
                    end
                endcase
            end
            S_DREAD: begin
                c_raddr = TRANS_ADDR[r_o];
                n_state = S_DSTART;
            end
            S_DSTART: begin
                if (r_det == '0) begin
                    n_value = '0;
                    n_sing  = 1'b1;
                    n_sat   = 1'b0;
                    n_state = S_OUT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DWAIT;
                end
            end
            S_DWAIT: begin
                if (div_done) begin
                    n_value = div_res.value;
                    n_sat   = div_res.sat;
                    n_sing  = 1'b0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (r_o == 4'(N_ELEM - 1)) begin
                        n_state = S_LOAD;
                    end else begin
                        n_o     = r_o + 1'b1;
                        n_state = S_DREAD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    assign o_stall     = (r_state != S_LOAD);
    assign o_valid     = (r_state == S_OUT);
    assign o_value     = r_value;
    assign o_singular  = r_sing;
    assign o_saturated = r_sat;
    assign o_last      = (r_o == 4'(N_ELEM - 1));

endmodule
`default_nettype wire

// ----- design/mi3_chk.sv -----
// Port-level checker for the 3x3 matrix inverse and its bind to the top level.
`default_nettype none
module mi3_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_value,
    input wire logic        o_singular,
    input wire logic        o_saturated
);

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_value == 32'd0 && !o_saturated)
        else $error("singular beat with nonzero value or saturation");

    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_value == 32'h7FFFFFFF || o_value == 32'h80000000)
        else $error("saturated beat not at a range limit");

    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while a result is pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value))
        else $error("stalled result beat changed");

endmodule

bind matrix_inverse_3x3 mi3_chk u_mi3_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_value     (o_value),
    .o_singular  (o_singular),
    .o_saturated (o_saturated)
);
`default_nettype wire

// ----- verif/matrix_inverse_3x3_checker.sv -----
// Checker that predicts the inverse of each loaded matrix and compares the result beats.
`timescale 1ns / 1ps
module matrix_inverse_3x3_checker
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int IN_WIDTH  = DEF_IN_WIDTH
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                i_stall_in,
    input wire logic [IN_WIDTH-1:0] i_element,
    input wire logic                i_out_valid,
    input wire logic                i_out_stall,
    input wire logic [OUT_WIDTH-1:0] i_value,
    input wire logic                i_singular,
    input wire logic                i_saturated,
    input wire logic                i_last,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic [OUT_WIDTH-1:0] value;
        logic                 singular;
        logic                 saturated;
        logic                 last;
    } t_inv_beat;

    t_inv_beat inverse_queue[$];
    logic signed [IN_WIDTH-1:0] held_elems [N_ELEM];
    int elem_count;

    function automatic logic signed [127:0] elem_at(int r, int c);
        return 128'(held_elems[r * 3 + c]);
    endfunction

    task automatic predict_inverse();
        logic signed [127:0] cof [N_ELEM];
        logic signed [127:0] det, num;
        logic [127:0] mag_n, mag_d, quot;
        logic neg;
        t_inv_beat b;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                cof[r * 3 + c] = elem_at((r + 1) % 3, (c + 1) % 3) * elem_at((r + 2) % 3, (c + 2) % 3)
                               - elem_at((r + 1) % 3, (c + 2) % 3) * elem_at((r + 2) % 3, (c + 1) % 3);
        det = elem_at(0, 0) * cof[0] + elem_at(0, 1) * cof[1] + elem_at(0, 2) * cof[2];
        for (int k = 0; k < N_ELEM; k++) begin
            b = '0;
            b.last = (k == N_ELEM - 1);
            if (det == 0) begin
                b.singular = 1'b1;
            end else begin
                num = cof[(k % 3) * 3 + k / 3];
                neg = num[127] ^ det[127];
                mag_n = num[127] ? -num : num;
                mag_d = det[127] ? -det : det;
                quot = (mag_n << (2 * FRAC_BITS)) / mag_d;
                if (!neg) begin
                    if (quot > 128'h7FFF_FFFF) begin
                        b.value = 32'h7FFF_FFFF;
                        b.saturated = 1'b1;
                    end else begin
                        b.value = quot[31:0];
                    end
                end else begin
                    if (quot > 128'h8000_0000) begin
                        b.value = 32'h8000_0000;
                        b.saturated = 1'b1;
                    end else begin
                        b.value = -quot[31:0];
                    end
                end
            end
            inverse_queue.push_back(b);
        end
    endtask

    always @(posedge i_clk) begin
        t_inv_beat e;
        if (!i_rst_n) begin
            elem_count <= 0;
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_valid && !i_stall_in) begin
                held_elems[elem_count] = i_element;
                if (elem_count == N_ELEM - 1) begin
                    elem_count <= 0;
                    predict_inverse();
                end else begin
                    elem_count <= elem_count + 1;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (inverse_queue.size() == 0) begin
                    $error("unexpected result beat, value %h", i_value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = inverse_queue.pop_front();
                    if (e.value !== i_value || e.singular !== i_singular
                            || e.saturated !== i_saturated || e.last !== i_last) begin
                        if (e.value !== i_value)
                            $error("value: expected %h, actual %h", e.value, i_value);
                        if (e.singular !== i_singular)
                            $error("singular: expected %b, actual %b", e.singular, i_singular);
                        if (e.saturated !== i_saturated)
                            $error("saturated: expected %b, actual %b", e.saturated, i_saturated);
                        if (e.last !== i_last)
                            $error("last: expected %b, actual %b", e.last, i_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= inverse_queue.size();
        end
    end

endmodule

// ----- verif/matrix_inverse_3x3_tb.sv -----
// Testbench top that feeds matrices to the 3x3 inverse and reports the verdict.
`timescale 1ns / 1ps
module matrix_inverse_3x3_tb;
    import mi3_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [DEF_IN_WIDTH-1:0] i_element = '0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_singular, o_saturated, o_last;
    logic [OUT_WIDTH-1:0] o_value;
    int fail_count, pending, cycle_count;
    int stall_left = 0;
    localparam int CYCLE_LIMIT = 4_000_000;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    matrix_inverse_3x3 uut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_element,
        .o_valid, .i_stall, .o_value, .o_singular, .o_saturated, .o_last
    );

    matrix_inverse_3x3_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_element,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_value(o_value),
        .i_singular(o_singular), .i_saturated(o_saturated), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 120);
    endfunction

    task automatic send_element(logic [DEF_IN_WIDTH-1:0] v);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_element <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_matrix(logic [DEF_IN_WIDTH-1:0] m [N_ELEM]);
        for (int k = 0; k < N_ELEM; k++) send_element(m[k]);
    endtask

    function automatic logic [DEF_IN_WIDTH-1:0] rand_element(int kind);
        case (kind)
            0: return DEF_IN_WIDTH'($urandom);
            1: return DEF_IN_WIDTH'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            default: return DEF_IN_WIDTH'($signed($urandom_range(0, 1 << 10)) - (1 << 9));
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
            stall_left <= gap_len();
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [DEF_IN_WIDTH-1:0] m [N_ELEM];
        int kind;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Identity, a singular matrix of extremes and a saturating diagonal matrix.
        m = '{24'h010000, 0, 0, 0, 24'h010000, 0, 0, 0, 24'h010000};
        send_matrix(m);
        m = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
              24'h000001, 24'hFFFFFF, 24'h000000};
        send_matrix(m);
        m = '{24'h7FFFFF, 0, 0, 0, 24'h800000, 0, 0, 0, 24'h000001};
        send_matrix(m);
        for (int n = 0; n < 23; n++) begin
            kind = $urandom_range(0, 2);
            for (int k = 0; k < N_ELEM; k++) m[k] = rand_element(kind);
            if (n % 7 == 3) for (int k = 0; k < 3; k++) m[6 + k] = m[k];
            send_matrix(m);
        end
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/mi3_pkg.sv
design/mi3_ram.sv
design/mi3_div.sv
design/matrix_inverse_3x3.sv
design/mi3_chk.sv
verif/matrix_inverse_3x3_checker.sv
verif/matrix_inverse_3x3_tb.sv
